>>> src/swtg_pkg.sv
`timescale 1ns / 1ps
package swtg_pkg;

   localparam int CLOCK_W      = 32;
   localparam int FREQ_W       = 16;
   localparam int OP_W         = 2;
   localparam int COUNTER_BITS = 8;
   localparam int PRESCALE_W   = 10;
   localparam int CODE_W       = 3;
   localparam int SHIFT_W      = 4;
   localparam int DIVISOR_W    = PRESCALE_W + 1;

   localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd16000000;

   // Operation codes on the request channel
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

   // Prescaler codes
   localparam logic [CODE_W-1:0] CODE_STOPPED = 3'd0;
   localparam logic [CODE_W-1:0] CODE_FIRST   = 3'd1;
   localparam logic [CODE_W-1:0] CODE_LAST    = 3'd7;

   localparam logic [COUNTER_BITS-1:0] COMPARE_MAX = {COUNTER_BITS{1'b1}};

   // Classified command passed from front to back
   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_START     = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_STOP_CLR  = 3'd3,
      CMD_NOP       = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [FREQ_W-1:0]   freq;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   // Prescaler divide ratio for each code
   function automatic logic [DIVISOR_W-1:0] prescale_divisor(input logic [CODE_W-1:0] code);
      logic [DIVISOR_W-1:0] d;
      case (code)
         3'd2:    d = 11'd8;
         3'd3:    d = 11'd32;
         3'd4:    d = 11'd64;
         3'd5:    d = 11'd128;
         3'd6:    d = 11'd256;
         3'd7:    d = 11'd1024;
         default: d = 11'd1;
      endcase
      return d;
   endfunction

   // log2 of the prescaler divide ratio
   function automatic logic [SHIFT_W-1:0] prescale_shift(input logic [CODE_W-1:0] code);
      logic [SHIFT_W-1:0] s;
      case (code)
         3'd2:    s = 4'd3;
         3'd3:    s = 4'd5;
         3'd4:    s = 4'd6;
         3'd5:    s = 4'd7;
         3'd6:    s = 4'd8;
         3'd7:    s = 4'd10;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

>>> src/swtg_ifs.sv
`timescale 1ns / 1ps
interface swtg_req_if
   import swtg_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [FREQ_W-1:0] frequency;

   modport source (output valid, output operation, output frequency, input ready);
   modport sink   (input valid, input operation, input frequency, output ready);
endinterface

interface swtg_rsp_if
   import swtg_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic                    pin_level;
   logic [CODE_W-1:0]       prescale_select;
   logic [COUNTER_BITS-1:0] compare_out;
   logic                    range_error;

   modport source (output valid, output pin_level, output prescale_select,
                   output compare_out, output range_error, input ready);
   modport sink   (input valid, input pin_level, input prescale_select,
                   input compare_out, input range_error, output ready);
endinterface

>>> src/swtg_front.sv
`timescale 1ns / 1ps
module swtg_front
   import swtg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   swtg_req_if.sink       req_bus,
   output queue_head_type head,
   input  logic           head_pop
);

   localparam int DEPTH = 2;

   queue_entry_type mem_ff [DEPTH];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   queue_entry_type entry;
   logic            push;
   logic            pop;

   // Classify the incoming operation
   always_comb begin
      entry.freq = req_bus.frequency;
      unique case (req_bus.operation)
         OP_TICK:  entry.cmd = CMD_TICK;
         OP_START: entry.cmd = (req_bus.frequency == '0) ? CMD_STOP_CLR : CMD_START;
         OP_STOP:  entry.cmd = CMD_STOP;
         default:  entry.cmd = CMD_NOP;
      endcase
   end

   assign req_bus.ready = (count_ff != 2'(DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign pop           = head_pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.entry = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

>>> src/swtg_div.sv
`timescale 1ns / 1ps
module swtg_div
   import swtg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [CLOCK_W-1:0] dividend,
   input  logic [FREQ_W-1:0]  divisor,
   output logic               done,
   output logic [CLOCK_W-1:0] quotient
);

   localparam int COUNT_W = $clog2(CLOCK_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [CLOCK_W-1:0] quot_ff, quot_in;
   logic [FREQ_W-1:0]  rem_ff, rem_in;
   logic [FREQ_W-1:0]  divisor_ff, divisor_in;
   logic [FREQ_W:0]    shifted_rem;
   logic [FREQ_W+1:0]  diff;

   // One restoring step: one quotient bit per cycle
   always_comb begin
      shifted_rem = {rem_ff, quot_ff[CLOCK_W-1]};
      diff        = {1'b0, shifted_rem} - {2'b0, divisor_ff};
      busy_in     = busy_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = COUNT_W'(CLOCK_W - 1);
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         if (!diff[FREQ_W+1]) begin
            rem_in  = diff[FREQ_W-1:0];
            quot_in = {quot_ff[CLOCK_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted_rem[FREQ_W-1:0];
            quot_in = {quot_ff[CLOCK_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Hold datapath values
   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> src/swtg_back.sv
`timescale 1ns / 1ps
module swtg_back
   import swtg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  queue_head_type     head,
   output logic               head_pop,
   input  logic [CLOCK_W-1:0] clock_hz,
   swtg_rsp_if.source         rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [PRESCALE_W-1:0]   pcount_ff, pcount_in;
   logic [COUNTER_BITS-1:0] tcount_ff, tcount_in;
   logic [COUNTER_BITS-1:0] compare_ff, compare_in;
   logic [CODE_W-1:0]       code_ff, code_in;
   logic                    level_ff, level_in;
   logic                    sat_ff, sat_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    out_free;
   logic                    div_start;
   logic                    div_done;
   logic [CLOCK_W-1:0]      div_quot;
   logic [CLOCK_W-2:0]      half_quot;
   logic                    fit_found;
   logic [CODE_W-1:0]       fit_code;
   logic [CLOCK_W-2:0]      fit_q;
   logic [DIVISOR_W-1:0]    pcount_next;

   // clock_hz / frequency; the final halving is a shift
   swtg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_hz),
      .divisor  (head.entry.freq),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign half_quot = div_quot[CLOCK_W-1:1];
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // Pick the first prescaler whose reduced quotient fits the counter
   always_comb begin
      logic [CLOCK_W-2:0] shifted;
      fit_found = 1'b0;
      fit_code  = CODE_LAST;
      fit_q     = '0;
      for (int c = 1; c <= 7; c++) begin
         shifted = half_quot >> prescale_shift(CODE_W'(c));
         if (!fit_found && shifted <= (CLOCK_W-1)'(1 << COUNTER_BITS)) begin
            fit_found = 1'b1;
            fit_code  = CODE_W'(c);
            fit_q     = shifted;
         end
      end
   end

   assign pcount_next = {1'b0, pcount_ff} + DIVISOR_W'(1);

   // Execute commands and update timer state
   always_comb begin
      state_in     = state_ff;
      pcount_in    = pcount_ff;
      tcount_in    = tcount_ff;
      compare_in   = compare_ff;
      code_in      = code_ff;
      level_in     = level_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      head_pop     = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && out_free) begin
               head_pop = 1'b1;
               if (head.entry.cmd == CMD_START) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  rsp_valid_in = 1'b1;
                  case (head.entry.cmd) inside
                     CMD_TICK: begin
                        if (code_ff != CODE_STOPPED) begin
                           if (pcount_next >= prescale_divisor(code_ff)) begin
                              pcount_in = '0;
                              if (tcount_ff == compare_ff) begin
                                 tcount_in = '0;
                                 level_in  = ~level_ff;
                              end else begin
                                 tcount_in = tcount_ff + 1'b1;
                              end
                           end else begin
                              pcount_in = pcount_next[PRESCALE_W-1:0];
                           end
                        end
                     end
                     CMD_STOP, CMD_STOP_CLR: begin
                        code_in    = CODE_STOPPED;
                        compare_in = '0;
                        pcount_in  = '0;
                        tcount_in  = '0;
                        level_in   = 1'b0;
                        if (head.entry.cmd == CMD_STOP_CLR) begin
                           sat_in = 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               pcount_in    = '0;
               tcount_in    = '0;
               if (half_quot == '0) begin
                  code_in    = CODE_FIRST;
                  compare_in = '0;
                  sat_in     = 1'b1;
               end else if (fit_found) begin
                  code_in    = fit_code;
                  compare_in = COUNTER_BITS'(fit_q - (CLOCK_W-1)'(1));
                  sat_in     = 1'b0;
               end else begin
                  code_in    = CODE_LAST;
                  compare_in = COMPARE_MAX;
                  sat_in     = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pcount_ff    <= '0;
         tcount_ff    <= '0;
         compare_ff   <= '0;
         code_ff      <= CODE_STOPPED;
         level_ff     <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcount_ff    <= pcount_in;
         tcount_ff    <= tcount_in;
         compare_ff   <= compare_in;
         code_ff      <= code_in;
         level_ff     <= level_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // State changes only when a new result is loaded, so it drives the payload
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.pin_level       = level_ff;
   assign rsp_bus.prescale_select = code_ff;
   assign rsp_bus.compare_out     = compare_ff;
   assign rsp_bus.range_error     = sat_ff;

endmodule

>>> src/square_wave_tone_generator_unit.sv
`timescale 1ns / 1ps
// Square-wave tone generator: clear-on-compare timer behind a prescaler.
// Request channel (req_bus): operation 0 = tick, 1 = start with frequency,
// 2 = stop; operation 3 is ignored. Every request gives one transfer on
// the response channel (rsp_bus) showing pin level, prescaler code,
// compare value and range flag after that request.
// csr_wr_en/csr_wr_data write clock_hz, used for the compare computation;
// write it only while the block is idle.
// A two-entry queue separates request intake from execution.
// Tick and stop: queue entry, then response register; one per cycle sustained
// while the receiver is ready. Start: the 32-step serial divider forms
// clock_hz / frequency one quotient bit per cycle; later requests wait.
// Reset clears the timer to stopped with pin low and clock_hz to 16 MHz.
// When the receiver stalls, the finished response holds and execution
// waits; the queue keeps taking requests until both entries are full.
module square_wave_tone_generator_unit
   import swtg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   swtg_req_if.sink           req_bus,
   swtg_rsp_if.source         rsp_bus,
   input  logic               csr_wr_en,
   input  logic [CLOCK_W-1:0] csr_wr_data
);

   logic [CLOCK_W-1:0] clock_hz_ff, clock_hz_in;
   queue_head_type     head;
   logic               head_pop;

   // Hold the clock frequency register
   assign clock_hz_in = csr_wr_en ? csr_wr_data : clock_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET;
      end else begin
         clock_hz_ff <= clock_hz_in;
      end
   end

   swtg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .head     (head),
      .head_pop (head_pop)
   );

   swtg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .clock_hz (clock_hz_ff),
      .rsp_bus  (rsp_bus)
   );

endmodule

>>> tb/square_wave_tone_generator_unit_tb.sv
`timescale 1ns / 1ps
module square_wave_tone_generator_unit_tb;
   import swtg_pkg::*;

   localparam int RESET_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 40;

   // Operation code the block ignores
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Divide ratio per prescaler code; code 0 never counts
   localparam int unsigned PRESCALE_RATIO [8] = '{1, 1, 8, 32, 64, 128, 256, 1024};

   typedef struct packed {
      logic                    pin;
      logic [CODE_W-1:0]       code;
      logic [COUNTER_BITS-1:0] compare;
      logic                    range_err;
   } tone_status_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [CLOCK_W-1:0]  csr_wr_data;

   swtg_req_if req_bus ();
   swtg_rsp_if rsp_bus ();

   square_wave_tone_generator_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Timer state as the block should hold it
   logic [CLOCK_W-1:0]      tone_clock_hz     = CLOCK_RESET;
   logic [PRESCALE_W-1:0]   tone_prescale_cnt = '0;
   logic [COUNTER_BITS-1:0] tone_timer_cnt    = '0;
   logic [COUNTER_BITS-1:0] tone_compare      = '0;
   logic [CODE_W-1:0]       tone_code         = CODE_STOPPED;
   logic                    tone_pin          = 1'b0;
   logic                    tone_sat          = 1'b0;

   tone_status_type pending_status [$];

   int  sent_items         = 0;
   int  counted_items      = 0;
   int  responses_checked  = 0;
   int  mismatch_count     = 0;
   int  toggle_count       = 0;
   int  sat_count          = 0;
   int  clock_settings     = 1;
   int  cycle_count        = 0;
   int  hold_off_asked     = 0;
   bit  sender_idle_en     = 1'b0;
   bit  receiver_idle_en   = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic void tone_halt();
      tone_code         = CODE_STOPPED;
      tone_compare      = '0;
      tone_prescale_cnt = '0;
      tone_timer_cnt    = '0;
      tone_pin          = 1'b0;
   endfunction

   function automatic void tone_start(input logic [FREQ_W-1:0] freq);
      longint unsigned half_period;
      longint unsigned quotient;
      int              code;
      if (freq == '0) begin
         tone_halt();
         tone_sat = 1'b0;
         return;
      end
      tone_prescale_cnt = '0;
      tone_timer_cnt    = '0;
      half_period = tone_clock_hz;
      half_period = half_period / freq / 2;
      // Saturate a frequency above half the clock to the fastest setting
      if (half_period == 0) begin
         tone_code    = CODE_FIRST;
         tone_compare = '0;
         tone_sat     = 1'b1;
         sat_count++;
         return;
      end
      // Take the first prescaler whose compare value fits the counter
      for (code = CODE_FIRST; code <= CODE_LAST; code++) begin
         quotient = half_period / PRESCALE_RATIO[code];
         if (quotient >= 1 && quotient - 1 <= COMPARE_MAX) begin
            tone_code    = code[CODE_W-1:0];
            tone_compare = quotient[COUNTER_BITS-1:0] - 1'b1;
            tone_sat     = 1'b0;
            return;
         end
      end
      // Nothing fits: saturate to the slowest setting
      tone_code    = CODE_LAST;
      tone_compare = COMPARE_MAX;
      tone_sat     = 1'b1;
      sat_count++;
   endfunction

   function automatic void tone_tick();
      if (tone_code == CODE_STOPPED)
         return;
      if (int'(tone_prescale_cnt) + 1 >= PRESCALE_RATIO[tone_code]) begin
         tone_prescale_cnt = '0;
         if (tone_timer_cnt == tone_compare) begin
            tone_timer_cnt = '0;
            tone_pin       = ~tone_pin;
            toggle_count++;
         end else begin
            tone_timer_cnt = tone_timer_cnt + 1'b1;
         end
      end else begin
         tone_prescale_cnt = tone_prescale_cnt + 1'b1;
      end
   endfunction

   function automatic tone_status_type predict_tone(input logic [OP_W-1:0] op,
                                                    input logic [FREQ_W-1:0] freq);
      case (op)
         OP_TICK:  tone_tick();
         OP_START: tone_start(freq);
         OP_STOP:  tone_halt();
         default:  ;
      endcase
      return '{pin: tone_pin, code: tone_code, compare: tone_compare, range_err: tone_sat};
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Check each response transfer, then queue the prediction for each request transfer
   always @(posedge clock) begin : tone_monitor
      tone_status_type seen;
      tone_status_type want;
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen = '{pin: rsp_bus.pin_level, code: rsp_bus.prescale_select,
                     compare: rsp_bus.compare_out, range_err: rsp_bus.range_error};
            responses_checked++;
            if (pending_status.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing pending",
                                         responses_checked));
            end else begin
               want = pending_status.pop_front();
               if (seen.pin !== want.pin)
                  report_mismatch($sformatf("response %0d pin_level %b, want %b",
                                            responses_checked, seen.pin, want.pin));
               if (seen.code !== want.code)
                  report_mismatch($sformatf("response %0d prescale_select %0d, want %0d",
                                            responses_checked, seen.code, want.code));
               if (seen.compare !== want.compare)
                  report_mismatch($sformatf("response %0d compare_out %0d, want %0d",
                                            responses_checked, seen.compare, want.compare));
               if (seen.range_err !== want.range_err)
                  report_mismatch($sformatf("response %0d range_error %b, want %b",
                                            responses_checked, seen.range_err,
                                            want.range_err));
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            pending_status.push_back(predict_tone(req_bus.operation, req_bus.frequency));
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d of %0d responses",
                  cycle_count, responses_checked, sent_items);
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   function automatic int idle_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random stalls plus a long hold on request
   initial begin : tone_receiver
      int stall_left;
      int hold_left;
      int hold_seen;
      stall_left    = 0;
      hold_left     = 0;
      hold_seen     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_asked != hold_seen) begin
            hold_seen = hold_off_asked;
            hold_left = LONG_HOLD;
         end
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            if (stall_left == 0 && receiver_idle_en && $urandom_range(0, 99) < 20)
               stall_left = idle_gap();
            if (stall_left > 0) begin
               rsp_bus.ready <= 1'b0;
               stall_left--;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // Offer one request and hold it until the transfer; valid stays high on return
   task automatic send_request(input logic [OP_W-1:0] op, input logic [FREQ_W-1:0] freq);
      int gap;
      gap = (sender_idle_en && $urandom_range(0, 99) < 25) ? idle_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.frequency <= freq;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent_items++;
      if (op != OP_UNUSED)
         counted_items++;
   endtask

   // Drop valid and wait for every response still owed
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (responses_checked < sent_items);
   endtask

   task automatic set_clock_hz(input logic [CLOCK_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      tone_clock_hz = value;
      clock_settings++;
   endtask

   function automatic logic [FREQ_W-1:0] pick_frequency();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         return '0;
      if (r < 14)
         return FREQ_W'($urandom_range(0, 65535));
      if (r < 18)
         return '1;
      return FREQ_W'($urandom_range(1, 1200));
   endfunction

   // ---------------------------------------------------------------- tests

   // Commands at the reset clock, starting from the stopped state
   task automatic test_stopped_commands();
      sender_idle_en   = 1'b1;
      receiver_idle_en = 1'b1;
      send_request(OP_TICK, '1);
      send_request(OP_UNUSED, 16'h1234);
      send_request(OP_STOP, '0);
      send_request(OP_START, '0);
      send_request(OP_START, 16'd1);      // too low: slowest setting, flag set
      send_request(OP_START, '1);
      send_request(OP_TICK, '0);
      send_request(OP_TICK, '0);
      send_request(OP_UNUSED, '0);
      send_request(OP_START, '0);         // zero frequency clears the flag
      send_request(OP_START, 16'd1);
      send_request(OP_STOP, '0);          // stop keeps the flag
      send_request(OP_TICK, '0);
   endtask

   // Clock register at both ends and at a value that gives compare zero
   task automatic test_clock_extremes();
      set_clock_hz(32'd1);
      send_request(OP_START, 16'd1);      // too high: fastest setting, flag set
      send_request(OP_TICK, '0);
      send_request(OP_TICK, '1);
      send_request(OP_START, '1);
      send_request(OP_TICK, '0);
      set_clock_hz('1);
      send_request(OP_START, 16'd1);
      send_request(OP_START, '1);
      send_request(OP_START, 16'd32768);
      set_clock_hz(32'd2000);
      send_request(OP_START, 16'd1000);
      repeat (3) send_request(OP_TICK, '0);
      send_request(OP_START, 16'd1);
   endtask

   // Run the divide-by-8 prescaler through a full timer wrap
   task automatic test_prescaler_wrap();
      set_clock_hz(32'd514);
      sender_idle_en   = 1'b0;
      receiver_idle_en = 1'b1;
      send_request(OP_START, 16'd1);
      repeat (300) send_request(OP_TICK, FREQ_W'($urandom_range(0, 65535)));
      send_request(OP_STOP, '0);
      send_request(OP_START, 16'd1);
      repeat (20) send_request(OP_TICK, '0);
   endtask

   // Hold the receiver off while requests keep coming, then pause the sender
   task automatic test_backpressure();
      set_clock_hz(32'd2000);
      sender_idle_en   = 1'b0;
      receiver_idle_en = 1'b0;
      send_request(OP_START, 16'd500);
      hold_off_asked++;
      repeat (24) send_request(OP_TICK, '0);
      wait_drained();
      repeat (10) send_request(OP_TICK, '0);
   endtask

   // Start a tone, tick it for a while, sometimes stop; mix in stray requests
   task automatic run_tone_phase(input logic [CLOCK_W-1:0] clk_hz, input int n_items);
      int target;
      int burst;
      set_clock_hz(clk_hz);
      target = counted_items + n_items;
      while (counted_items < target) begin
         sender_idle_en   = ($urandom_range(0, 99) < 70);
         receiver_idle_en = ($urandom_range(0, 99) < 70);
         if ($urandom_range(0, 99) < 80) begin
            send_request(OP_START, pick_frequency());
            burst = ($urandom_range(0, 99) < 6) ? $urandom_range(80, 150) : $urandom_range(1, 40);
            repeat (burst) begin
               if ($urandom_range(0, 99) < 8)
                  send_request(OP_W'($urandom_range(0, 3)), pick_frequency());
               else
                  send_request(OP_TICK, FREQ_W'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 99) < 30)
               send_request(OP_STOP, FREQ_W'($urandom_range(0, 65535)));
         end else begin
            repeat ($urandom_range(1, 5))
               send_request(OP_W'($urandom_range(0, 3)), FREQ_W'($urandom_range(0, 65535)));
         end
      end
   endtask

   task automatic test_random_tones();
      run_tone_phase(32'd2000, 220);
      run_tone_phase(CLOCK_RESET, 130);
      run_tone_phase(32'd1, 80);
      run_tone_phase('1, 90);
      run_tone_phase(32'd40000, 180);
      run_tone_phase(32'd300, 180);
      run_tone_phase(CLOCK_W'($urandom_range(1, 200000)), 180);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_TICK;
      req_bus.frequency <= '0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_stopped_commands();
      test_clock_extremes();
      test_prescaler_wrap();
      test_backpressure();
      test_random_tones();

      // Let any stray transfer show up before the final tally
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_status.size() != 0)
         report_mismatch($sformatf("%0d expected responses never arrived",
                                   pending_status.size()));

      $display("Checked %0d responses to %0d requests over %0d clock settings",
               responses_checked, sent_items, clock_settings);
      $display("Saw %0d pin toggles and %0d saturated starts; %0d mismatches",
               toggle_count, sat_count, mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
